// ===== rtl/sll_pkg.sv =====
package sll_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int LETTER_W     = 5;

    localparam logic [LETTER_W-1:0] LETTER_LIMIT = LETTER_W'(26);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [LETTER_W-1:0] letter;
    } t_cell_ctl;

endpackage

// ===== rtl/sll_cell.sv =====
module sll_cell
    import sll_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [CW-1:0]       i_count,
    input  logic [LETTER_W-1:0] i_prev_letter,
    input  logic                i_prev_lt,
    input  logic [LETTER_W-1:0] i_next_letter,
    input  logic [LETTER_W-1:0] i_first_letter,
    output logic [LETTER_W-1:0] o_letter,
    output logic                o_lt,
    output logic                o_match
);

    logic [LETTER_W-1:0] r_letter;
    logic [LETTER_W-1:0] n_letter;
    logic                occ;
    logic                wrap;

    assign occ     = CW'(IDX) < i_count;
    assign o_lt    = occ && (r_letter < i_ctl.letter);
    assign o_match = occ && (r_letter == i_ctl.letter);
    assign wrap    = (CW'(IDX + 1) == i_count);

    always_comb begin
        n_letter = r_letter;
        case (i_ctl.op)
            OP_INSERT: begin
                // entries ahead of the insert point stay, the rest move back one
                if (!o_lt) begin
                    n_letter = i_prev_lt ? i_ctl.letter : i_prev_letter;
                end
            end
            OP_REMOVE: begin
                if (!o_lt) begin
                    n_letter = i_next_letter;
                end
            end
            OP_ROTATE: begin
                // the last occupied cell picks up the head word
                n_letter = wrap ? i_first_letter : i_next_letter;
            end
            default: begin
                n_letter = r_letter;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_letter <= n_letter;
    end

    assign o_letter = r_letter;

endmodule

// ===== rtl/sorted_letter_list.sv =====
// Sorted letter list: an ascending multiset of letter indexes (0 = a .. 25 = z)
// kept in a row of CAPACITY cells, each holding one entry.
// Command channel: a word (i_letter, i_mode) is taken at a rising edge with
// start high and busy low. Mode 0 inserts the letter, mode 1 removes one copy.
// Letters above 25 leave the list unchanged with both flags clear.
// The edit happens in the accept cycle in all cells at once. Then the list is
// read out of the head cell while the row rotates by one cell a cycle, so after
// N results the row is back in order.
// Result channel: o_valid marks each result for exactly one cycle; the receiver
// cannot stall it. One result per entry, o_last on the final one. An empty list
// gives one result with o_empty_res set and o_entry zero. o_dropped and
// o_not_found are the same on every result of one listing.
// The accept edge moves the control to the emit state; each result is then
// registered into o_valid and o_entry. busy stays high until the last result
// of the listing is registered, so no word is taken while a listing is emitted;
// the listing pace is set by the one-entry-a-cycle rotation of the cell row.
// Reset: synchronous, active low; clears the entry count and control state.
module sorted_letter_list
    import sll_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_mode,
    output logic                o_valid,
    output logic [LETTER_W-1:0] o_entry,
    output logic                o_last,
    output logic                o_empty_res,
    output logic                o_dropped,
    output logic                o_not_found
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_dropped, n_dropped;
    logic                r_not_found, n_not_found;
    logic                r_valid, n_valid;
    logic [LETTER_W-1:0] r_entry, n_entry;
    logic                r_last, n_last;
    logic                r_empty, n_empty;

    t_cell_ctl           ctl;
    logic [LETTER_W-1:0] cell_letter [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_match;
    logic                found;
    logic                letter_ok;
    logic                full;
    logic                final_word;

    assign found      = |cell_match;
    assign letter_ok  = i_letter < LETTER_LIMIT;
    assign full       = (r_count == CW'(CAPACITY));
    assign final_word = (CW'(r_idx + 1'b1) == r_count);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [LETTER_W-1:0] prev_letter;
        logic                prev_lt;
        logic [LETTER_W-1:0] next_letter;

        if (g == 0) begin : g_head
            assign prev_letter = cell_letter[0];
            assign prev_lt     = 1'b1;
        end else begin : g_body
            assign prev_letter = cell_letter[g-1];
            assign prev_lt     = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_letter = cell_letter[g];
        end else begin : g_mid
            assign next_letter = cell_letter[g+1];
        end

        sll_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (ctl),
            .i_count        (r_count),
            .i_prev_letter  (prev_letter),
            .i_prev_lt      (prev_lt),
            .i_next_letter  (next_letter),
            .i_first_letter (cell_letter[0]),
            .o_letter       (cell_letter[g]),
            .o_lt           (cell_lt[g]),
            .o_match        (cell_match[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_dropped   = r_dropped;
        n_not_found = r_not_found;
        n_valid     = 1'b0;
        n_entry     = r_entry;
        n_last      = r_last;
        n_empty     = r_empty;
        ctl.op      = OP_HOLD;
        ctl.letter  = i_letter;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_dropped   = 1'b0;
                    n_not_found = 1'b0;
                    n_idx       = '0;
                    n_state     = ST_EMIT;
                    if (letter_ok) begin
                        if (i_mode == MODE_INSERT) begin
                            if (full) begin
                                n_dropped = 1'b1;
                            end else begin
                                ctl.op  = OP_INSERT;
                                n_count = CW'(r_count + 1'b1);
                            end
                        end else begin
                            if (found) begin
                                ctl.op  = OP_REMOVE;
                                n_count = CW'(r_count - 1'b1);
                            end else begin
                                n_not_found = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_EMIT: begin
                n_valid = 1'b1;
                if (r_count == '0) begin
                    n_entry = '0;
                    n_last  = 1'b1;
                    n_empty = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    ctl.op  = OP_ROTATE;
                    n_entry = cell_letter[0];
                    n_last  = final_word;
                    n_empty = 1'b0;
                    n_idx   = CW'(r_idx + 1'b1);
                    if (final_word) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_dropped   <= n_dropped;
        r_not_found <= n_not_found;
        r_entry     <= n_entry;
        r_last      <= n_last;
        r_empty     <= n_empty;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_entry     = r_entry;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;
    assign o_dropped   = r_dropped;
    assign o_not_found = r_not_found;

endmodule

// ===== dv/sll_checker.sv =====
module sll_checker
    import sll_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_mode,
    input  logic                o_valid,
    input  logic [LETTER_W-1:0] o_entry,
    input  logic                o_last,
    input  logic                o_empty_res,
    input  logic                o_dropped,
    input  logic                o_not_found,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [LETTER_W-1:0] entry;
        logic                last;
        logic                empty;
        logic                dropped;
        logic                not_found;
    } t_listing_row;

    logic [LETTER_W-1:0] letters_mem [CAPACITY];
    int                  entry_cnt;
    t_listing_row        listing_q [$];
    int                  fail_cnt;

    initial begin
        entry_cnt    = 0;
        fail_cnt     = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Apply one word to the shadow list and queue the listing it produces.
    task automatic update_list(input logic [LETTER_W-1:0] letter, input logic mode);
        int           pos;
        int           k;
        logic         full_f;
        logic         miss_f;
        t_listing_row row;
        full_f = 1'b0;
        miss_f = 1'b0;
        if (letter < LETTER_LIMIT) begin
            if (mode == MODE_INSERT) begin
                if (entry_cnt >= CAPACITY) begin
                    full_f = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < entry_cnt && letters_mem[pos] < letter) pos++;
                    for (k = entry_cnt; k > pos; k--) letters_mem[k] = letters_mem[k-1];
                    letters_mem[pos] = letter;
                    entry_cnt++;
                end
            end else begin
                pos = 0;
                while (pos < entry_cnt && letters_mem[pos] != letter) pos++;
                if (pos >= entry_cnt) begin
                    miss_f = 1'b1;
                end else begin
                    for (k = pos; k + 1 < entry_cnt; k++) letters_mem[k] = letters_mem[k+1];
                    entry_cnt--;
                end
            end
        end
        if (entry_cnt == 0) begin
            row = '{entry: '0, last: 1'b1, empty: 1'b1, dropped: full_f, not_found: miss_f};
            listing_q.push_back(row);
        end else begin
            for (k = 0; k < entry_cnt; k++) begin
                row.entry     = letters_mem[k];
                row.last      = (k + 1 == entry_cnt);
                row.empty     = 1'b0;
                row.dropped   = full_f;
                row.not_found = miss_f;
                listing_q.push_back(row);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_listing_row exp_row;
        if (!i_rst_n) begin
            entry_cnt = 0;
            listing_q.delete();
        end else begin
            // Check the result first: a word taken at this edge lists only later.
            if (o_valid) begin
                if (listing_q.size() == 0) begin
                    $error("unexpected result: entry %0d last %0b", o_entry, o_last);
                    fail_cnt++;
                end else begin
                    exp_row = listing_q.pop_front();
                    if (o_entry !== exp_row.entry) begin
                        $error("entry mismatch: expected %0d, got %0d", exp_row.entry, o_entry);
                        fail_cnt++;
                    end
                    if (o_last !== exp_row.last) begin
                        $error("last mismatch: expected %0b, got %0b", exp_row.last, o_last);
                        fail_cnt++;
                    end
                    if (o_empty_res !== exp_row.empty) begin
                        $error("empty_res mismatch: expected %0b, got %0b",
                               exp_row.empty, o_empty_res);
                        fail_cnt++;
                    end
                    if (o_dropped !== exp_row.dropped) begin
                        $error("dropped mismatch: expected %0b, got %0b",
                               exp_row.dropped, o_dropped);
                        fail_cnt++;
                    end
                    if (o_not_found !== exp_row.not_found) begin
                        $error("not_found mismatch: expected %0b, got %0b",
                               exp_row.not_found, o_not_found);
                        fail_cnt++;
                    end
                end
            end
            if (start && !busy) update_list(i_letter, i_mode);
        end
        o_fail_count <= fail_cnt;
        o_pending    <= listing_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import sll_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                start    = 1'b0;
    logic [LETTER_W-1:0] i_letter = '0;
    logic                i_mode   = MODE_INSERT;
    logic                busy;
    logic                o_valid;
    logic [LETTER_W-1:0] o_entry;
    logic                o_last;
    logic                o_empty_res;
    logic                o_dropped;
    logic                o_not_found;
    int                  fail_count;
    int                  pending;
    int                  cycle_count = 0;

    int phase_count  [4] = '{45, 20, 15, 12};
    int phase_idle   [4] = '{0, 61, 0, 30};
    int phase_insert [4] = '{95, 50, 15, 50};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sorted_letter_list #(
        .CAPACITY(CAPACITY_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_letter    (i_letter),
        .i_mode      (i_mode),
        .o_valid     (o_valid),
        .o_entry     (o_entry),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_dropped   (o_dropped),
        .o_not_found (o_not_found)
    );

    sll_checker #(
        .CAPACITY(CAPACITY_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_letter     (i_letter),
        .i_mode       (i_mode),
        .o_valid      (o_valid),
        .o_entry      (o_entry),
        .o_last       (o_last),
        .o_empty_res  (o_empty_res),
        .o_dropped    (o_dropped),
        .o_not_found  (o_not_found),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one word after a random gap and hold it until it is taken.
    task automatic send_word(input logic [LETTER_W-1:0] letter, input logic mode,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_letter <= letter;
        i_mode   <= mode;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int                  ph;
        int                  sent;
        logic [LETTER_W-1:0] letter;
        logic                mode;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(5'd5,  MODE_REMOVE, 0);   // remove from empty list
        send_word(5'd0,  MODE_INSERT, 0);
        send_word(5'd25, MODE_INSERT, 0);
        send_word(5'd25, MODE_INSERT, 0);   // duplicate at the tail
        send_word(5'd12, MODE_INSERT, 0);
        send_word(5'd0,  MODE_INSERT, 0);   // duplicate at the head
        send_word(5'd12, MODE_REMOVE, 0);
        send_word(5'd7,  MODE_REMOVE, 0);   // no match
        send_word(5'd26, MODE_INSERT, 0);   // not a letter
        send_word(5'd31, MODE_REMOVE, 0);
        send_word(5'd31, MODE_INSERT, 0);
        send_word(5'd0,  MODE_REMOVE, 0);
        send_word(5'd0,  MODE_REMOVE, 0);
        send_word(5'd25, MODE_REMOVE, 0);
        send_word(5'd25, MODE_REMOVE, 0);
        send_word(5'd13, MODE_INSERT, 0);
        send_word(5'd13, MODE_REMOVE, 0);
        send_word(5'd13, MODE_REMOVE, 0);
        wait_drained();

        // Fill past capacity, then mix, drain and mix again.
        for (ph = 0; ph < 4; ph++) begin
            sent = 0;
            while (sent < phase_count[ph]) begin
                if ($urandom_range(99) < 5) letter = LETTER_W'($urandom_range(26, 31));
                else letter = LETTER_W'($urandom_range(0, 25));
                mode = ($urandom_range(99) < phase_insert[ph]) ? MODE_INSERT : MODE_REMOVE;
                send_word(letter, mode, phase_idle[ph]);
                if (letter < LETTER_LIMIT) sent++;
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sll_pkg.sv
rtl/sll_cell.sv
rtl/sorted_letter_list.sv
dv/sll_checker.sv
dv/testbench.sv
